// ----- rtl/core/gco_pkg.sv -----
// Shared types and constants for the greedy coverage ordering block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package gco_pkg;

  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int SCORE_W = 32;
  localparam int SUM_W   = 36;
  localparam int CNT_W   = 6;
  // covered entries never go below zero, so one bit less than a score
  localparam int COV_W   = SCORE_W - 1;

  typedef struct packed {
    logic [ROW_W-1:0]          row_index;
    logic [COL_W-1:0]          column_index;
    logic signed [SCORE_W-1:0] score;
    logic                      final_element;
  } gco_elem_t;

  typedef struct packed {
    logic [ROW_W-1:0] chosen_dataset;
    logic [SUM_W-1:0] gain;
    logic [SUM_W-1:0] covered_total;
    logic             empty_result;
    logic             last_pick;
  } gco_result_t;

  typedef enum logic {
    OP_SCAN,
    OP_UPDATE
  } gco_op_t;

  typedef enum logic [1:0] {
    PUSH_PICK,
    PUSH_LAST,
    PUSH_EMPTY
  } gco_push_t;

  typedef struct packed {
    logic             load_write;
    logic             clear;
    logic             round_init;
    logic             rd_en;
    gco_op_t          rd_op;
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;
    logic             rd_first;
    logic             rd_last;
    logic             commit;
    logic             push;
    gco_push_t        push_kind;
  } gco_cmd_t;

  typedef struct packed {
    logic             busy;
    logic             best_valid;
    logic             pend_valid;
    logic             out_free;
    logic [ROW_W-1:0] best_row;
  } gco_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/gco_chan_if.sv -----
// Valid/ready channel carrying one payload per transfer.
// The payload type is set where the channel is instantiated; no dependencies.
`default_nettype none

interface gco_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/greedy_coverage_order.sv -----
// Greedy maximum-coverage ordering of an N-by-N score matrix.
//
// Channels: "element" takes one matrix element per transfer (row_index,
// column_index, signed Q16.16 score, final_element); "result" gives one
// transfer per pick (chosen_dataset, gain, covered_total, empty_result,
// last_pick). cfg_write/cfg_data set dataset_count (N); the user must write
// it only while idle, as the block itself does not enforce this. Loading:
// one element per cycle. The element with final_element set is stored and
// starts the ordering; element.ready stays low until the last result of
// that ordering sits in the output register. Ordering: each round scans
// all N rows through the matrix RAM read port, one element per cycle, then
// replays the chosen row to update coverage, for up to N+1 rounds. Each
// pick is pushed at the decision step of the round after it; the last one
// or the empty result at the decision of the round that finds no pick.
// A pick is held one round back so its last_pick flag is known; if nothing
// is picked a single result with empty_result set is given.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before pushing the next one. Reset returns to loading
// and sets N to 32; matrix contents are not cleared.
// Depends on gco_pkg, gco_chan_if, gco_ctrl, gco_dp and gco_ram.
`default_nettype none

module greedy_coverage_order #(
  parameter int MAX_DATASETS = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [gco_pkg::CNT_W-1:0] cfg_data,
  gco_chan_if.sink                       element,
  gco_chan_if.source                     result
);
  import gco_pkg::*;

  gco_elem_t   elem_pl;
  gco_result_t out_data;
  gco_cmd_t    cmd;
  gco_sts_t    sts;
  logic        elem_ready;
  logic        out_valid;

  assign elem_pl        = element.payload;
  assign element.ready  = elem_ready;
  assign result.valid   = out_valid;
  assign result.payload = out_data;

  gco_ctrl #(
    .MAX_DATASETS (MAX_DATASETS)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .elem_valid (element.valid),
    .elem_final (elem_pl.final_element),
    .elem_ready (elem_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  gco_dp #(
    .MAX_DATASETS (MAX_DATASETS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .elem      (elem_pl),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/gco_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the score matrix; no dependencies.
`default_nettype none

module gco_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/gco_ctrl.sv -----
// Sequencer for loading, scanning rounds, covered-vector updates and result pushes.
// Depends on gco_pkg; drives the datapath through gco_cmd_t, watches gco_sts_t.
`default_nettype none

module gco_ctrl #(
  parameter int MAX_DATASETS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [gco_pkg::CNT_W-1:0]       cfg_data,
  input  wire logic                            elem_valid,
  input  wire logic                            elem_final,
  output      logic                            elem_ready,
  input  wire gco_pkg::gco_sts_t               sts,
  output      gco_pkg::gco_cmd_t               cmd
);
  import gco_pkg::*;

  localparam int ROW_LIMIT = (MAX_DATASETS < 32) ? MAX_DATASETS : 32;
  localparam int RW        = $clog2(ROW_LIMIT);
  localparam logic [CNT_W-1:0] LIMIT_V = CNT_W'(ROW_LIMIT);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ROUND,
    ST_SCAN,
    ST_SCAN_WAIT,
    ST_DECIDE,
    ST_UPDATE,
    ST_UPDATE_WAIT
  } state_t;

  state_t            state;
  logic [RW-1:0]     row_cnt;
  logic [RW-1:0]     col_cnt;
  logic [RW-1:0]     n_last;
  logic [CNT_W-1:0]  dataset_count;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  count_m1;
  logic              col_end;
  logic              row_end;

  // saturate the register to 1 .. ROW_LIMIT
  always_comb begin
    if (dataset_count == '0) begin
      count_eff = CNT_W'(1);
    end else if (dataset_count > LIMIT_V) begin
      count_eff = LIMIT_V;
    end else begin
      count_eff = dataset_count;
    end
    count_m1 = count_eff - CNT_W'(1);
  end

  assign col_end    = (col_cnt == n_last);
  assign row_end    = (row_cnt == n_last);
  assign elem_ready = (state == ST_LOAD);

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_LOAD: begin
        cmd.load_write = elem_valid;
        cmd.clear      = elem_valid & elem_final;
      end
      ST_ROUND: begin
        cmd.round_init = 1'b1;
      end
      ST_SCAN: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_op    = OP_SCAN;
        cmd.rd_row   = ROW_W'(row_cnt);
        cmd.rd_col   = COL_W'(col_cnt);
        cmd.rd_first = (col_cnt == '0);
        cmd.rd_last  = col_end;
      end
      ST_DECIDE: begin
        if (sts.best_valid) begin
          // hand the previous pick out before the new one replaces it
          if (!sts.pend_valid || sts.out_free) begin
            cmd.commit    = 1'b1;
            cmd.push      = sts.pend_valid;
            cmd.push_kind = PUSH_PICK;
          end
        end else if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = sts.pend_valid ? PUSH_LAST : PUSH_EMPTY;
        end
      end
      ST_UPDATE: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_op    = OP_UPDATE;
        cmd.rd_row   = sts.best_row;
        cmd.rd_col   = COL_W'(col_cnt);
        cmd.rd_first = (col_cnt == '0);
        cmd.rd_last  = col_end;
      end
      ST_SCAN_WAIT, ST_UPDATE_WAIT: begin
        cmd = '0;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      row_cnt       <= '0;
      col_cnt       <= '0;
      n_last        <= '0;
      dataset_count <= CNT_W'(32);
    end else begin
      if (cfg_write) begin
        dataset_count <= cfg_data;
      end
      unique case (state)
        ST_LOAD: begin
          if (elem_valid && elem_final) begin
            n_last <= count_m1[RW-1:0];
            state  <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          row_cnt <= '0;
          col_cnt <= '0;
          state   <= ST_SCAN;
        end
        ST_SCAN: begin
          if (col_end) begin
            col_cnt <= '0;
            if (row_end) begin
              state <= ST_SCAN_WAIT;
            end else begin
              row_cnt <= row_cnt + RW'(1);
            end
          end else begin
            col_cnt <= col_cnt + RW'(1);
          end
        end
        ST_SCAN_WAIT: begin
          if (!sts.busy) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (sts.best_valid) begin
            if (!sts.pend_valid || sts.out_free) begin
              col_cnt <= '0;
              state   <= ST_UPDATE;
            end
          end else if (sts.out_free) begin
            state <= ST_LOAD;
          end
        end
        ST_UPDATE: begin
          if (col_end) begin
            col_cnt <= '0;
            state   <= ST_UPDATE_WAIT;
          end else begin
            col_cnt <= col_cnt + RW'(1);
          end
        end
        ST_UPDATE_WAIT: begin
          if (!sts.busy) begin
            state <= ST_ROUND;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gco_dp.sv -----
// Datapath: score matrix RAM, covered vector, gain pipeline, best tracker,
// pending pick and output register. Depends on gco_pkg and gco_ram.
`default_nettype none

module gco_dp #(
  parameter int MAX_DATASETS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire gco_pkg::gco_cmd_t     cmd,
  output      gco_pkg::gco_sts_t     sts,
  input  wire gco_pkg::gco_elem_t    elem,
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      gco_pkg::gco_result_t  out_data
);
  import gco_pkg::*;

  localparam int ROW_LIMIT = (MAX_DATASETS < 32) ? MAX_DATASETS : 32;
  localparam int RW        = $clog2(ROW_LIMIT);
  localparam int AW        = 2 * RW;
  localparam int DEPTH     = 1 << AW;
  localparam logic [6:0] MAX_V = 7'(MAX_DATASETS);

  logic                in_range;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [AW-1:0]       ram_raddr;
  logic [SCORE_W-1:0]  ram_rdata;

  logic [COV_W-1:0]    cov [ROW_LIMIT];
  logic [ROW_LIMIT-1:0] chosen;
  logic [SUM_W-1:0]    covered_sum;
  logic [SUM_W-1:0]    sum_next;

  // stage 1: RAM data arrives
  logic                s1_valid;
  gco_op_t             s1_op;
  logic [RW-1:0]       s1_row;
  logic [RW-1:0]       s1_col;
  logic                s1_first;
  logic                s1_last;
  logic [COV_W-1:0]    cov_rd;
  logic [SCORE_W:0]    diff;
  logic [COV_W-1:0]    term;
  logic                cov_raise;

  // stage 2: accumulate the row gain
  logic                s2_valid;
  logic                s2_first;
  logic                s2_last;
  logic [RW-1:0]       s2_row;
  logic [COV_W-1:0]    s2_term;
  logic [SUM_W-1:0]    acc;

  // stage 3: compare against the best row so far
  logic                s3_valid;
  logic [RW-1:0]       s3_row;
  logic                best_valid;
  logic [SUM_W-1:0]    best_gain;
  logic [RW-1:0]       best_row;

  logic                pend_valid;
  logic [RW-1:0]       pend_row;
  logic [SUM_W-1:0]    pend_gain;
  logic [SUM_W-1:0]    pend_total;

  assign in_range  = ({2'b00, elem.row_index} < MAX_V) && ({2'b00, elem.column_index} < MAX_V);
  assign ram_we    = cmd.load_write && in_range;
  assign ram_waddr = {elem.row_index[RW-1:0], elem.column_index[RW-1:0]};
  assign ram_raddr = {cmd.rd_row[RW-1:0], cmd.rd_col[RW-1:0]};

  gco_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (elem.score),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // per-column gain is the positive part of score minus covered value
  always_comb begin
    cov_rd    = cov[s1_col];
    diff      = {ram_rdata[SCORE_W-1], ram_rdata} - {2'b00, cov_rd};
    term      = (!diff[SCORE_W] && (diff != '0)) ? diff[COV_W-1:0] : '0;
    cov_raise = !ram_rdata[SCORE_W-1] && (ram_rdata[COV_W-1:0] > cov_rd);
  end

  assign sum_next = covered_sum + best_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid && (s1_op == OP_SCAN);
      s3_valid <= s2_valid && s2_last;
    end
  end

  always_ff @(posedge clk) begin
    s1_op    <= cmd.rd_op;
    s1_row   <= cmd.rd_row[RW-1:0];
    s1_col   <= cmd.rd_col[RW-1:0];
    s1_first <= cmd.rd_first;
    s1_last  <= cmd.rd_last;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s2_row   <= s1_row;
    s2_term  <= term;
    s3_row   <= s2_row;
    if (s2_valid) begin
      acc <= (s2_first ? '0 : acc) + SUM_W'(s2_term);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      for (int k = 0; k < ROW_LIMIT; k++) begin
        cov[k] <= '0;
      end
    end else if (s1_valid && (s1_op == OP_UPDATE) && cov_raise) begin
      cov[s1_col] <= ram_rdata[COV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_gain  <= '0;
      best_row   <= '0;
    end else if (cmd.round_init) begin
      best_valid <= 1'b0;
      best_gain  <= '0;
    end else if (s3_valid && !chosen[s3_row] && (acc > best_gain)) begin
      // strict compare: the lower row keeps a tie
      best_valid <= 1'b1;
      best_gain  <= acc;
      best_row   <= s3_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chosen      <= '0;
      covered_sum <= '0;
      pend_valid  <= 1'b0;
    end else if (cmd.clear) begin
      chosen      <= '0;
      covered_sum <= '0;
      pend_valid  <= 1'b0;
    end else if (cmd.commit) begin
      chosen[best_row] <= 1'b1;
      covered_sum      <= sum_next;
      pend_valid       <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      pend_row   <= best_row;
      pend_gain  <= best_gain;
      pend_total <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      unique case (cmd.push_kind)
        PUSH_PICK, PUSH_LAST: begin
          out_data.chosen_dataset <= ROW_W'(pend_row);
          out_data.gain           <= pend_gain;
          out_data.covered_total  <= pend_total;
          out_data.empty_result   <= 1'b0;
          out_data.last_pick      <= (cmd.push_kind == PUSH_LAST);
        end
        PUSH_EMPTY: begin
          out_data.chosen_dataset <= '0;
          out_data.gain           <= '0;
          out_data.covered_total  <= '0;
          out_data.empty_result   <= 1'b1;
          out_data.last_pick      <= 1'b1;
        end
        default: begin
          out_data <= '0;
        end
      endcase
    end
  end

  always_comb begin
    sts.busy       = s1_valid | s2_valid | s3_valid;
    sts.best_valid = best_valid;
    sts.pend_valid = pend_valid;
    sts.out_free   = !out_valid || out_ready;
    sts.best_row   = ROW_W'(best_row);
  end

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for greedy_coverage_order: loads score matrices and checks every pick it orders.
// Depends on gco_pkg, gco_chan_if and the greedy_coverage_order RTL.

module tb_top;
  import gco_pkg::*;

  // one full scan round at 32 rows, plus margin
  localparam int SETTLE_CYCLES = 1100;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write;
  logic [CNT_W-1:0] cfg_data;

  gco_chan_if #(.payload_t(gco_elem_t))   elem_ch ();
  gco_chan_if #(.payload_t(gco_result_t)) res_ch ();

  greedy_coverage_order dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .element   (elem_ch),
    .result    (res_ch)
  );

  // mirror of the block's state
  logic signed [SCORE_W-1:0] score_model [32][32];
  bit                        written_model [32][32];
  logic [CNT_W-1:0]          count_model = 6'd32;
  gco_result_t               expected_picks [$];

  int send_idle_pct = 23;
  int recv_idle_pct = 49;
  int items_sent    = 0;
  int fail_count    = 0;
  int cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_rows(input logic [CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > 32) return 32;
    return 32'(c);
  endfunction

  // Greedy ordering over the stored matrix; appends the picks it yields.
  function automatic void order_rows();
    gco_result_t picks [$];
    gco_result_t pick;
    longint      covered [32];
    longint      total, best_gain, portion, s;
    int          best, i, j;
    int unsigned n;
    bit [31:0]   chosen;
    n = active_rows(count_model);
    foreach (covered[k]) covered[k] = 0;
    total  = 0;
    chosen = '0;
    while (picks.size() < n) begin
      best      = -1;
      best_gain = 0;
      for (i = 0; i < n; i++) begin
        if (!chosen[i]) begin
          portion = 0;
          for (j = 0; j < n; j++) begin
            s = score_model[i][j];
            portion += (s > covered[j]) ? s : covered[j];
          end
          // strict compare keeps the lowest index on a tie
          if (portion - total > best_gain) begin
            best_gain = portion - total;
            best      = i;
          end
        end
      end
      if (best < 0) break;
      for (j = 0; j < n; j++) begin
        s = score_model[best][j];
        if (s > covered[j]) covered[j] = s;
      end
      total += best_gain;
      chosen[best] = 1'b1;
      pick.chosen_dataset = best[ROW_W-1:0];
      pick.gain           = best_gain[SUM_W-1:0];
      pick.covered_total  = total[SUM_W-1:0];
      pick.empty_result   = 1'b0;
      pick.last_pick      = 1'b0;
      picks = {picks, pick};
    end
    if (picks.size() == 0) begin
      pick = '0;
      pick.empty_result = 1'b1;
      picks = {picks, pick};
    end
    foreach (picks[k]) begin
      pick = picks[k];
      pick.last_pick = (k == picks.size() - 1);
      expected_picks = {expected_picks, pick};
    end
  endfunction

  function automatic logic [31:0] pick_score();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 30) return 32'($urandom_range(0, 4)) << 16;
    else if (sel < 50) return {1'b1, 31'($urandom)};
    else if (sel < 70) return 32'($urandom);
    else if (sel < 85) return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
    else return 32'($urandom_range(0, 3));
  endfunction

  task automatic send_element(input int r, input int c, input logic [31:0] sc, input bit fin);
    gco_elem_t e;
    e.row_index     = r[ROW_W-1:0];
    e.column_index  = c[COL_W-1:0];
    e.score         = sc;
    e.final_element = fin;
    while ($urandom_range(99) < send_idle_pct) begin
      elem_ch.valid <= 1'b0;
      @(posedge clk);
    end
    elem_ch.valid   <= 1'b1;
    elem_ch.payload <= e;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    items_sent++;
    score_model[e.row_index][e.column_index]   = e.score;
    written_model[e.row_index][e.column_index] = 1'b1;
    if (e.final_element) order_rows();
  endtask

  // Drain all picks, let any trailing load finish, then write N.
  task automatic write_dataset_count(input int v);
    elem_ch.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v[CNT_W-1:0];
    count_model = v[CNT_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic test_single_dataset();
    write_dataset_count(1);
    send_element(0, 0, 32'h7FFF_FFFF, 1'b1);
    // zero acts as one row; nothing positive gives the empty result
    write_dataset_count(0);
    send_element(0, 0, 32'h8000_0000, 1'b1);
    send_element(0, 0, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_ties_and_stop();
    write_dataset_count(3);
    send_element(0, 0, 32'h0004_0000, 1'b0);
    send_element(0, 1, 32'h0004_0000, 1'b0);
    send_element(0, 2, 32'h0000_0000, 1'b0);
    send_element(1, 0, 32'h0004_0000, 1'b0);
    send_element(1, 1, 32'h0004_0000, 1'b0);
    send_element(1, 2, 32'h0000_0000, 1'b0);
    send_element(2, 0, 32'h0000_0000, 1'b0);
    send_element(2, 1, 32'h0000_0000, 1'b0);
    send_element(2, 2, 32'h0008_0000, 1'b1);
  endtask

  task automatic test_unused_and_fresh();
    write_dataset_count(2);
    // stored outside the active square, never read at this size
    send_element(31, 31, 32'h7FFF_FFFF, 1'b0);
    send_element(0, 0, 32'h8000_0000, 1'b0);
    send_element(0, 1, 32'h0000_0001, 1'b0);
    send_element(1, 0, 32'h7FFF_FFFF, 1'b0);
    send_element(1, 1, 32'h8000_0000, 1'b1);
    // overwrite one element and reorder from a cleared coverage
    send_element(0, 1, 32'h0000_0000, 1'b1);
  endtask

  task automatic test_long_ordering();
    int r, c;
    logic [31:0] sc;
    write_dataset_count(8);
    // diagonal dominates, so every row adds coverage: 8 picks
    for (r = 0; r < 8; r++)
      for (c = 0; c < 8; c++) begin
        if (r == c) sc = 32'h0100_0000 + 32'($urandom_range(0, 32'h00FF_FFFF));
        else if ($urandom_range(1) == 1) sc = {1'b1, 31'($urandom)};
        else sc = 32'($urandom_range(0, 32'h0000_FFFF));
        send_element(r, c, sc, r == 7 && c == 7);
      end
  endtask

  task automatic test_random_orderings(input int sp, input int rp, input int target);
    int start, sel, r, c, k, extra;
    int unsigned n;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(99) < 40) begin
        sel = $urandom_range(9);
        if (sel == 0) write_dataset_count(0);
        else if (sel == 1) write_dataset_count($urandom_range(7, 10));
        else write_dataset_count($urandom_range(1, 6));
      end
      n = active_rows(count_model);
      // never let the ordering read an element that was not loaded
      for (r = 0; r < n; r++)
        for (c = 0; c < n; c++)
          if (!written_model[r][c]) send_element(r, c, pick_score(), 1'b0);
      extra = $urandom_range(0, 2 * n);
      for (k = 0; k <= extra; k++) begin
        if ($urandom_range(99) < 80) begin
          r = $urandom_range(0, n - 1);
          c = $urandom_range(0, n - 1);
        end else begin
          r = $urandom_range(0, 31);
          c = $urandom_range(0, 31);
        end
        send_element(r, c, pick_score(), k == extra);
      end
    end
  endtask

  // result side: random stalls, compare each transfer with the oldest pick
  initial begin
    gco_result_t got, want;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_ch.valid && res_ch.ready) begin
        got = res_ch.payload;
        if (expected_picks.size() == 0) begin
          $error("unexpected result: chosen_dataset %0d gain %0d", got.chosen_dataset, got.gain);
          fail_count++;
        end else begin
          want = expected_picks.pop_front();
          if (got.chosen_dataset !== want.chosen_dataset) begin
            $error("chosen_dataset: expected %0d, got %0d", want.chosen_dataset,
                   got.chosen_dataset);
            fail_count++;
          end
          if (got.gain !== want.gain) begin
            $error("gain: expected %0d, got %0d", want.gain, got.gain);
            fail_count++;
          end
          if (got.covered_total !== want.covered_total) begin
            $error("covered_total: expected %0d, got %0d", want.covered_total,
                   got.covered_total);
            fail_count++;
          end
          if (got.empty_result !== want.empty_result) begin
            $error("empty_result: expected %0d, got %0d", want.empty_result,
                   got.empty_result);
            fail_count++;
          end
          if (got.last_pick !== want.last_pick) begin
            $error("last_pick: expected %0d, got %0d", want.last_pick, got.last_pick);
            fail_count++;
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // hang guard
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    elem_ch.valid   <= 1'b0;
    elem_ch.payload <= '0;
    cfg_write       <= 1'b0;
    cfg_data        <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_single_dataset();
    test_ties_and_stop();
    test_unused_and_fresh();
    test_long_ordering();
    test_random_orderings(23, 49, 40);
    test_random_orderings(49, 23, 40);
    test_random_orderings(0, 0, 40);
    elem_ch.valid <= 1'b0;
    while (expected_picks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_picks.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/gco_pkg.sv
rtl/core/gco_chan_if.sv
rtl/core/gco_ram.sv
rtl/core/gco_ctrl.sv
rtl/core/gco_dp.sv
rtl/core/greedy_coverage_order.sv
verif/tb_top.sv
